// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the link tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is held.
`define ASSERT_CLK_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked property, checked through reset as well.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/uclt_pkg.sv -----
// Shared constants, codes and control structs of the link tracker.
// No dependencies; used by the controller, datapath, top level and checker.
package uclt_pkg;

    localparam int PEND_DEPTH = 128;
    localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PEND_FW    = $clog2(PEND_DEPTH + 1);
    localparam int PEND_SW    = $clog2(2 * PEND_DEPTH);

    localparam logic [16:0] TIMER_MAX = 17'h1FFFF;
    localparam logic [15:0] WRAP_HI   = 16'hFF00;
    localparam logic [15:0] WRAP_LO   = 16'h00FF;
    localparam logic [10:0] MIN_LEN   = 11'd16;

    localparam logic [31:0] RST_PROTOCOL_ID  = 32'd0;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd10000;
    localparam logic [15:0] RST_HEARTBEAT_MS = 16'd1000;

    localparam logic [1:0] CFG_PROTOCOL_ID  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_MS   = 2'd1;
    localparam logic [1:0] CFG_HEARTBEAT_MS = 2'd2;

    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_PACKET     = 3'd1;
    localparam logic [2:0] MODE_CONNECT    = 3'd2;
    localparam logic [2:0] MODE_DISCONNECT = 3'd3;
    localparam logic [2:0] MODE_INPUT      = 3'd4;

    localparam logic [2:0] PT_ACCEPT      = 3'd0;
    localparam logic [2:0] PT_REJECT      = 3'd1;
    localparam logic [2:0] PT_SERVER_DISC = 3'd2;
    localparam logic [2:0] PT_SNAPSHOT    = 3'd3;

    localparam logic [1:0] LINK_DISC       = 2'd0;
    localparam logic [1:0] LINK_CONNECTING = 2'd1;
    localparam logic [1:0] LINK_CONNECTED  = 2'd2;

    localparam logic [1:0] PK_CONNECT    = 2'd0;
    localparam logic [1:0] PK_HEARTBEAT  = 2'd1;
    localparam logic [1:0] PK_INPUT      = 2'd2;
    localparam logic [1:0] PK_DISCONNECT = 2'd3;

    typedef enum logic [2:0] {
        REC_STATUS,
        REC_REFUSED,
        REC_HEARTBEAT,
        REC_CONNECT,
        REC_INPUT,
        REC_DISCONNECT
    } uclt_rec_t;

    typedef struct packed {
        logic        capture;
        logic        sum;
        logic        recv_upd;
        logic        hb_upd;
        logic        recv_clear;
        logic        hb_clear;
        logic        link_we;
        logic [1:0]  link_val;
        logic        track;
        logic        fill_clear;
        logic        push;
        logic        pop;
        logic        emit;
        uclt_rec_t   rec;
        logic        last;
    } uclt_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] link;
        logic       pkt_ok;
        logic [2:0] ptype;
        logic       timeout;
        logic       hb_due;
        logic       fill_zero;
        logic       pop_ok;
        logic       out_free;
    } uclt_status_t;

endpackage

// ----- hw/rtl/udp_client_link_tracker.sv -----
// Top level of the client link tracker: joins controller and datapath.
// Depends on uclt_pkg, uclt_ctrl and uclt_datapath.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata 112b, s_tuser 3b
//  m_        out        m_tvalid / m_tready  m_tdata 80b, m_tuser 3b, m_tlast
//  cfg_      in         cfg_we               cfg_index 2b, cfg_data 32b
//
// A request passes through accept, timer sums, execute and record load; a
// snapshot adds a queue trim that reads the head of the pending memory through
// its registered read port and compares it, popping entries while they are
// acknowledged; a second record adds another record load.
// Reset is synchronous: link state, sequences, timers, queue pointers and
// registers return to their defaults; the pending memory is not cleared.
// A stalled output holds its record; the controller waits before loading.
module udp_client_link_tracker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // delta_ms, pkt_length, pkt_protocol_id, pkt_sequence, pkt_ack,
    // pkt_type, input_sequence, zero pad
    input  logic [111:0]  s_tdata,
    // mode
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // packet_sequence, packet_ack, packet_ack_bits, link_state, refused,
    // pending_count, zero pad
    output logic [79:0]   m_tdata,
    // has_packet, packet_kind
    output logic [2:0]    m_tuser,
    output logic          m_tlast
);
    import uclt_pkg::*;

    uclt_cmd_t    cmd;
    uclt_status_t st;

    uclt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    uclt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hw/rtl/uclt_datapath.sv -----
// Datapath of the link tracker: config registers, link and sequence state,
// timers, pending queue memory and the output record register. Uses uclt_pkg.
module uclt_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [111:0]          s_tdata,
    input  logic [2:0]            s_tuser,
    input  uclt_pkg::uclt_cmd_t   cmd,
    output uclt_pkg::uclt_status_t st,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,
    output logic [2:0]            m_tuser,
    output logic                  m_tlast
);
    import uclt_pkg::*;

    logic [31:0] protocol_id_reg;
    logic [15:0] timeout_reg;
    logic [15:0] heartbeat_reg;

    logic [2:0]  mode_reg;
    logic [15:0] delta_reg;
    logic [10:0] plen_reg;
    logic [31:0] pid_reg;
    logic [15:0] pseq_reg;
    logic [15:0] pack_reg;
    logic [2:0]  ptype_reg;
    logic [15:0] iseq_reg;

    logic [1:0]  link_reg;
    logic [15:0] local_seq_reg;
    logic [15:0] remote_reg, remote_next;
    logic [31:0] ack_reg, ack_next;
    logic [16:0] recv_reg;
    logic [16:0] hb_reg;
    logic [16:0] recv_sat_reg;
    logic [16:0] hb_sat_reg;

    logic [15:0]        pend_mem [PEND_DEPTH];
    logic [15:0]        rdata_reg;
    logic [PEND_AW-1:0] head_reg, head_inc, wr_addr;
    logic [PEND_FW-1:0] fill_reg;
    logic [PEND_SW-1:0] wr_sum;
    logic               full;

    logic        out_valid_reg;
    logic        out_has_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_seq_reg;
    logic [15:0] out_ack_reg;
    logic [31:0] out_bits_reg;
    logic [1:0]  out_link_reg;
    logic        out_refused_reg;
    logic [7:0]  out_count_reg;
    logic        out_last_reg;

    logic [17:0] recv_sum, hb_sum;
    logic        newer, in_win;
    logic [15:0] diff;
    logic [4:0]  dm1;
    logic [31:0] bitmask, shifted;
    logic        rec_has;
    logic [1:0]  rec_kind;
    logic [15:0] rec_ack;
    logic [31:0] rec_bits;

    assign recv_sum = 18'(recv_reg) + 18'(delta_reg);
    assign hb_sum   = 18'(hb_reg) + 18'(delta_reg);

    always_comb begin
        newer   = (pseq_reg > remote_reg) || (remote_reg > WRAP_HI && pseq_reg < WRAP_LO);
        diff    = newer ? (pseq_reg - remote_reg) : (remote_reg - pseq_reg);
        in_win  = (diff != 16'd0) && (diff <= 16'd32);
        dm1     = 5'(diff - 16'd1);
        bitmask = 32'd1 << dm1;
        shifted = (diff == 16'd32) ? 32'd0 : (ack_reg << diff[4:0]);
        remote_next = remote_reg;
        ack_next    = ack_reg;
        if (newer) begin
            remote_next = pseq_reg;
            ack_next    = in_win ? (shifted | bitmask) : 32'd0;
        end else if (in_win) begin
            ack_next = ack_reg | bitmask;
        end
    end

    always_comb begin
        head_inc = (head_reg == PEND_AW'(PEND_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        full     = (fill_reg == PEND_FW'(PEND_DEPTH));
        wr_sum   = PEND_SW'(head_reg) + PEND_SW'(fill_reg);
        if (wr_sum >= PEND_SW'(PEND_DEPTH)) begin
            wr_sum = wr_sum - PEND_SW'(PEND_DEPTH);
        end
        wr_addr = full ? head_reg : wr_sum[PEND_AW-1:0];
    end

    always_comb begin
        rec_has  = 1'b1;
        rec_kind = PK_CONNECT;
        rec_ack  = 16'd0;
        rec_bits = 32'd0;
        case (cmd.rec)
            REC_HEARTBEAT: begin
                rec_kind = PK_HEARTBEAT;
                rec_ack  = remote_reg;
                rec_bits = ack_reg;
            end
            REC_INPUT: begin
                rec_kind = PK_INPUT;
                rec_ack  = remote_reg;
                rec_bits = ack_reg;
            end
            REC_CONNECT:    rec_kind = PK_CONNECT;
            REC_DISCONNECT: rec_kind = PK_DISCONNECT;
            default:        rec_has  = 1'b0;
        endcase
    end

    always_comb begin
        st.mode      = mode_reg;
        st.link      = link_reg;
        st.pkt_ok    = (plen_reg >= MIN_LEN) && (pid_reg == protocol_id_reg);
        st.ptype     = ptype_reg;
        st.timeout   = (recv_sat_reg >= 17'(timeout_reg));
        st.hb_due    = (hb_sat_reg >= 17'(heartbeat_reg));
        st.fill_zero = (fill_reg == '0);
        st.pop_ok    = (rdata_reg <= pack_reg);
        st.out_free  = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            pend_mem[wr_addr] <= iseq_reg;
        end
        rdata_reg <= pend_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tuser;
            delta_reg <= s_tdata[15:0];
            plen_reg  <= s_tdata[26:16];
            pid_reg   <= s_tdata[58:27];
            pseq_reg  <= s_tdata[74:59];
            pack_reg  <= s_tdata[90:75];
            ptype_reg <= s_tdata[93:91];
            iseq_reg  <= s_tdata[109:94];
        end
        if (cmd.sum) begin
            recv_sat_reg <= recv_sum[17] ? TIMER_MAX : recv_sum[16:0];
            hb_sat_reg   <= hb_sum[17] ? TIMER_MAX : hb_sum[16:0];
        end
        if (cmd.emit) begin
            out_has_reg     <= rec_has;
            out_kind_reg    <= rec_kind;
            out_seq_reg     <= rec_has ? local_seq_reg : 16'd0;
            out_ack_reg     <= rec_ack;
            out_bits_reg    <= rec_bits;
            out_link_reg    <= link_reg;
            out_refused_reg <= (cmd.rec == REC_REFUSED);
            out_count_reg   <= 8'(fill_reg);
            out_last_reg    <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_id_reg <= RST_PROTOCOL_ID;
            timeout_reg     <= RST_TIMEOUT_MS;
            heartbeat_reg   <= RST_HEARTBEAT_MS;
            link_reg        <= LINK_DISC;
            local_seq_reg   <= '0;
            remote_reg      <= '0;
            ack_reg         <= '0;
            recv_reg        <= '0;
            hb_reg          <= '0;
            head_reg        <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PROTOCOL_ID:  protocol_id_reg <= cfg_data;
                    CFG_TIMEOUT_MS:   timeout_reg     <= cfg_data[15:0];
                    CFG_HEARTBEAT_MS: heartbeat_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.link_we) begin
                link_reg <= cmd.link_val;
            end
            if (cmd.recv_clear) begin
                recv_reg <= '0;
            end else if (cmd.recv_upd) begin
                recv_reg <= recv_sat_reg;
            end
            if (cmd.hb_clear) begin
                hb_reg <= '0;
            end else if (cmd.hb_upd) begin
                hb_reg <= st.hb_due ? (hb_sat_reg - 17'(heartbeat_reg)) : hb_sat_reg;
            end
            if (cmd.track) begin
                remote_reg <= remote_next;
                ack_reg    <= ack_next;
            end
            if (cmd.fill_clear) begin
                head_reg <= '0;
                fill_reg <= '0;
            end else if (cmd.push) begin
                if (full) begin
                    head_reg <= head_inc;
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end else if (cmd.pop) begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.emit && rec_has) begin
                local_seq_reg <= local_seq_reg + 16'd1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_count_reg, out_refused_reg, out_link_reg,
                       out_bits_reg, out_ack_reg, out_seq_reg};
    assign m_tuser  = {out_kind_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/uclt_ctrl.sv -----
// Controller state machine of the link tracker: sequences each request
// through sum, execute, queue trim and record emission. Uses uclt_pkg.
module uclt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  uclt_pkg::uclt_status_t st,
    output uclt_pkg::uclt_cmd_t    cmd
);
    import uclt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_EXEC,
        ST_TRIM_RD,
        ST_TRIM_CMP,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    state_t    state_reg, state_next;
    uclt_rec_t rec_reg, rec_next;
    logic      second_reg, second_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd         = '0;
        cmd.rec     = REC_STATUS;
        state_next  = state_reg;
        rec_next    = rec_reg;
        second_next = second_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                rec_next    = REC_STATUS;
                second_next = 1'b0;
                state_next  = ST_EMIT1;
                case (st.mode)
                    MODE_TICK: begin
                        if (st.link != LINK_DISC) begin
                            cmd.recv_upd = 1'b1;
                            if (st.timeout) begin
                                cmd.link_we  = 1'b1;
                                cmd.link_val = LINK_DISC;
                            end else begin
                                cmd.hb_upd = 1'b1;
                                if (st.hb_due) begin
                                    rec_next    = REC_HEARTBEAT;
                                    second_next = (st.link == LINK_CONNECTING);
                                end
                            end
                        end
                    end
                    MODE_PACKET: begin
                        if (st.link != LINK_DISC && st.pkt_ok) begin
                            cmd.recv_clear = 1'b1;
                            cmd.track      = 1'b1;
                            if (st.ptype == PT_ACCEPT) begin
                                if (st.link == LINK_CONNECTING) begin
                                    cmd.link_we  = 1'b1;
                                    cmd.link_val = LINK_CONNECTED;
                                end
                            end else if (st.ptype inside {PT_REJECT, PT_SERVER_DISC}) begin
                                cmd.link_we  = 1'b1;
                                cmd.link_val = LINK_DISC;
                            end else if (st.ptype == PT_SNAPSHOT) begin
                                state_next = ST_TRIM_RD;
                            end
                        end
                    end
                    MODE_CONNECT: begin
                        if (st.link != LINK_DISC) begin
                            rec_next = REC_REFUSED;
                        end else begin
                            cmd.link_we    = 1'b1;
                            cmd.link_val   = LINK_CONNECTING;
                            cmd.recv_clear = 1'b1;
                            cmd.hb_clear   = 1'b1;
                            rec_next       = REC_CONNECT;
                        end
                    end
                    MODE_DISCONNECT: begin
                        if (st.link != LINK_DISC) begin
                            cmd.link_we    = 1'b1;
                            cmd.link_val   = LINK_DISC;
                            cmd.fill_clear = 1'b1;
                            rec_next       = REC_DISCONNECT;
                        end
                    end
                    MODE_INPUT: begin
                        if (st.link == LINK_CONNECTED) begin
                            cmd.push = 1'b1;
                            rec_next = REC_INPUT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_TRIM_RD: begin
                state_next = st.fill_zero ? ST_EMIT1 : ST_TRIM_CMP;
            end
            ST_TRIM_CMP: begin
                if (st.pop_ok) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_TRIM_RD;
                end else begin
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.rec    = rec_reg;
                    cmd.last   = !second_reg;
                    state_next = second_reg ? ST_EMIT2 : ST_IDLE;
                end
            end
            ST_EMIT2: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.rec    = REC_CONNECT;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rec_reg    <= REC_STATUS;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rec_reg    <= rec_next;
            second_reg <= second_next;
        end
    end

endmodule

// ----- hw/rtl/uclt_checker.sv -----
// Port-level checker of the link tracker, bound to the top level.
// Depends on assert_macros.svh and uclt_pkg.
`include "assert_macros.svh"

module uclt_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [79:0]   m_tdata,
    input logic [2:0]    m_tuser,
    input logic          m_tlast
);
    import uclt_pkg::*;

    logic status_clean;
    logic first_is_hb;

    assign status_clean = (m_tuser[2:1] == 2'd0) && (m_tdata[63:0] == 64'd0);
    assign first_is_hb  = m_tuser[0] && (m_tuser[2:1] == PK_HEARTBEAT);

    `ASSERT_CLK_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_CLK(a_rst_empty, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK_RST(a_status_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> status_clean)
    `ASSERT_CLK_RST(a_refused, aclk, aresetn, m_tvalid && m_tdata[66] |-> !m_tuser[0] && m_tlast)
    `ASSERT_CLK_RST(a_first_hb, aclk, aresetn, m_tvalid && !m_tlast |-> first_is_hb)

endmodule

bind udp_client_link_tracker uclt_checker u_chk (.*);

// ----- verif/udp_client_link_tracker_test.sv -----
// Self-checking testbench for udp_client_link_tracker: streams link events in,
// predicts every result record and checks the records that come out.
// Depends on uclt_pkg and the udp_client_link_tracker RTL.
module udp_client_link_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;
    import uclt_pkg::*;

    localparam logic [2:0] PT_PONG          = 3'd4;
    localparam logic [2:0] PT_VOICE         = 3'd5;
    localparam logic [2:0] PT_OTHER         = 3'd6;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [1:0] KIND_NONE        = 2'd0;
    localparam int         QUEUE_DEPTH      = PEND_DEPTH;
    localparam int         MAX_REPORTS      = 10;
    localparam int         FLOOD_EXTRA      = 12;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] delta_ms;
        logic [10:0] pkt_length;
        logic [31:0] pkt_protocol_id;
        logic [15:0] pkt_sequence;
        logic [15:0] pkt_ack;
        logic [2:0]  pkt_type;
        logic [15:0] input_sequence;
    } link_event_t;

    typedef struct {
        logic        has_packet;
        logic [1:0]  packet_kind;
        logic [15:0] packet_sequence;
        logic [15:0] packet_ack;
        logic [31:0] packet_ack_bits;
        logic [1:0]  link_state;
        logic        refused;
        logic [7:0]  pending_count;
        logic        last;
    } link_record_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [1:0]    cfg_index = CFG_PROTOCOL_ID;
    logic [31:0]   cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata   = '0;
    logic [2:0]    s_tuser   = MODE_TICK;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [79:0]   m_tdata;
    logic [2:0]    m_tuser;
    logic          m_tlast;

    udp_client_link_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // link state as the block should hold it
    logic [31:0]  cfg_protocol_id  = RST_PROTOCOL_ID;
    logic [15:0]  cfg_timeout_ms   = RST_TIMEOUT_MS;
    logic [15:0]  cfg_heartbeat_ms = RST_HEARTBEAT_MS;
    logic [1:0]   link_now         = LINK_DISC;
    logic [15:0]  local_seq        = '0;
    logic [15:0]  remote_seq       = '0;
    logic [31:0]  remote_field     = '0;
    logic [16:0]  recv_ms          = '0;
    logic [16:0]  beat_ms          = '0;
    logic [15:0]  pending_inputs[$];

    link_event_t  request_queue[$];
    link_record_t expected_records[$];
    link_event_t  cur_request;
    logic         request_taken    = 1'b0;
    int unsigned  send_gap         = 0;
    int unsigned  ready_hold       = 0;
    int unsigned  send_idle_pct    = 0;
    int unsigned  recv_stall_pct   = 0;
    int unsigned  items_issued     = 0;
    int unsigned  items_accepted   = 0;
    int unsigned  record_index     = 0;
    int unsigned  fault_count      = 0;
    logic [15:0]  gen_remote       = '0;
    logic [15:0]  gen_input        = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    task automatic add_record(input logic is_pkt, input logic [1:0] kind,
                              input logic [15:0] seq, input logic [15:0] ack,
                              input logic [31:0] bits, input logic is_refused,
                              input logic is_last);
        link_record_t rec;
        rec.has_packet      = is_pkt;
        rec.packet_kind     = kind;
        rec.packet_sequence = seq;
        rec.packet_ack      = ack;
        rec.packet_ack_bits = bits;
        rec.link_state      = link_now;
        rec.refused         = is_refused;
        rec.pending_count   = 8'(pending_inputs.size());
        rec.last            = is_last;
        expected_records = {expected_records, rec};
    endtask

    task automatic predict_event(input link_event_t ev);
        logic [17:0] sum;
        logic [15:0] gap;
        logic        done;
        done = 1'b0;
        case (ev.mode)
            MODE_TICK: if (link_now != LINK_DISC) begin
                sum = {1'b0, recv_ms} + ev.delta_ms;
                recv_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum[16:0];
                if (recv_ms >= cfg_timeout_ms) begin
                    link_now = LINK_DISC;
                end else begin
                    sum = {1'b0, beat_ms} + ev.delta_ms;
                    beat_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum[16:0];
                    if (beat_ms >= cfg_heartbeat_ms) begin
                        beat_ms = beat_ms - cfg_heartbeat_ms;
                        if (link_now == LINK_CONNECTING) begin
                            add_record(1'b1, PK_HEARTBEAT, local_seq, remote_seq, remote_field,
                                       1'b0, 1'b0);
                            add_record(1'b1, PK_CONNECT, local_seq + 16'd1, '0, '0,
                                       1'b0, 1'b1);
                            local_seq = local_seq + 16'd2;
                        end else begin
                            add_record(1'b1, PK_HEARTBEAT, local_seq, remote_seq, remote_field,
                                       1'b0, 1'b1);
                            local_seq = local_seq + 16'd1;
                        end
                        done = 1'b1;
                    end
                end
            end
            MODE_PACKET: if (link_now != LINK_DISC && ev.pkt_length >= MIN_LEN &&
                             ev.pkt_protocol_id == cfg_protocol_id) begin
                recv_ms = '0;
                if (ev.pkt_sequence > remote_seq ||
                    (remote_seq > WRAP_HI && ev.pkt_sequence < WRAP_LO)) begin
                    gap = ev.pkt_sequence - remote_seq;
                    if (gap >= 16'd1 && gap <= 16'd32) begin
                        remote_field = ((gap == 16'd32) ? 32'd0 : (remote_field << gap)) |
                                       (32'd1 << (gap - 16'd1));
                    end else begin
                        remote_field = '0;
                    end
                    remote_seq = ev.pkt_sequence;
                end else begin
                    gap = remote_seq - ev.pkt_sequence;
                    if (gap >= 16'd1 && gap <= 16'd32)
                        remote_field |= 32'd1 << (gap - 16'd1);
                end
                case (ev.pkt_type)
                    PT_ACCEPT: if (link_now == LINK_CONNECTING) link_now = LINK_CONNECTED;
                    PT_REJECT, PT_SERVER_DISC: link_now = LINK_DISC;
                    PT_SNAPSHOT: begin
                        while (pending_inputs.size() != 0 && pending_inputs[0] <= ev.pkt_ack)
                            pending_inputs.delete(0);
                    end
                    default: ;
                endcase
            end
            MODE_CONNECT: begin
                if (link_now != LINK_DISC) begin
                    add_record(1'b0, KIND_NONE, '0, '0, '0, 1'b1, 1'b1);
                end else begin
                    link_now = LINK_CONNECTING;
                    recv_ms  = '0;
                    beat_ms  = '0;
                    add_record(1'b1, PK_CONNECT, local_seq, '0, '0, 1'b0, 1'b1);
                    local_seq = local_seq + 16'd1;
                end
                done = 1'b1;
            end
            MODE_DISCONNECT: if (link_now != LINK_DISC) begin
                link_now = LINK_DISC;
                pending_inputs.delete();
                add_record(1'b1, PK_DISCONNECT, local_seq, '0, '0, 1'b0, 1'b1);
                local_seq = local_seq + 16'd1;
                done = 1'b1;
            end
            MODE_INPUT: if (link_now == LINK_CONNECTED) begin
                if (pending_inputs.size() >= QUEUE_DEPTH) pending_inputs.delete(0);
                pending_inputs = {pending_inputs, ev.input_sequence};
                add_record(1'b1, PK_INPUT, local_seq, remote_seq, remote_field, 1'b0, 1'b1);
                local_seq = local_seq + 16'd1;
                done = 1'b1;
            end
            default: ;
        endcase
        if (!done) add_record(1'b0, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
    endtask

    task automatic check_record(input link_record_t want, input link_record_t got);
        string diff;
        diff = "";
        if (got.has_packet !== want.has_packet)
            diff = {diff, $sformatf(" has_packet %0d/%0d", want.has_packet, got.has_packet)};
        if (got.packet_kind !== want.packet_kind)
            diff = {diff, $sformatf(" kind %0d/%0d", want.packet_kind, got.packet_kind)};
        if (got.packet_sequence !== want.packet_sequence)
            diff = {diff, $sformatf(" seq %h/%h", want.packet_sequence, got.packet_sequence)};
        if (got.packet_ack !== want.packet_ack)
            diff = {diff, $sformatf(" ack %h/%h", want.packet_ack, got.packet_ack)};
        if (got.packet_ack_bits !== want.packet_ack_bits)
            diff = {diff, $sformatf(" bitfield %h/%h", want.packet_ack_bits,
                                    got.packet_ack_bits)};
        if (got.link_state !== want.link_state)
            diff = {diff, $sformatf(" link %0d/%0d", want.link_state, got.link_state)};
        if (got.refused !== want.refused)
            diff = {diff, $sformatf(" refused %0d/%0d", want.refused, got.refused)};
        if (got.pending_count !== want.pending_count)
            diff = {diff, $sformatf(" pending %0d/%0d", want.pending_count,
                                    got.pending_count)};
        if (got.last !== want.last)
            diff = {diff, $sformatf(" last %0d/%0d", want.last, got.last)};
        if (diff != "") begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("record %0d mismatch (expected/actual):%s", record_index, diff);
        end
    endtask

    // hold a request until taken, then apply the gap before the next
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || request_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                cur_request = request_queue[0];
                request_queue.delete(0);
                s_tuser  <= cur_request.mode;
                s_tdata  <= {2'b00, cur_request.input_sequence, cur_request.pkt_type,
                             cur_request.pkt_ack, cur_request.pkt_sequence,
                             cur_request.pkt_protocol_id, cur_request.pkt_length,
                             cur_request.delta_ms};
                s_tvalid <= 1'b1;
                send_gap = pick_gap(send_idle_pct);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            ready_hold = pick_gap(recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        link_record_t got;
        request_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.packet_sequence = m_tdata[15:0];
                got.packet_ack      = m_tdata[31:16];
                got.packet_ack_bits = m_tdata[63:32];
                got.link_state      = m_tdata[65:64];
                got.refused         = m_tdata[66];
                got.pending_count   = m_tdata[74:67];
                got.has_packet      = m_tuser[0];
                got.packet_kind     = m_tuser[2:1];
                got.last            = m_tlast;
                if (expected_records.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("record %0d arrived with nothing expected", record_index);
                end else begin
                    check_record(expected_records[0], got);
                    expected_records.delete(0);
                end
                record_index++;
            end
            if (s_tvalid && s_tready) begin
                predict_event(cur_request);
                items_accepted++;
            end
        end
    end

    function automatic link_event_t noise_event(input logic [2:0] mode);
        link_event_t ev;
        ev.mode            = mode;
        ev.delta_ms        = rand16();
        ev.pkt_length      = 11'($urandom);
        ev.pkt_protocol_id = $urandom;
        ev.pkt_sequence    = rand16();
        ev.pkt_ack         = rand16();
        ev.pkt_type        = 3'($urandom_range(PT_ACCEPT, PT_OTHER));
        ev.input_sequence  = rand16();
        return ev;
    endfunction

    function automatic link_event_t tick_event(input logic [15:0] delta);
        link_event_t ev;
        ev = noise_event(MODE_TICK);
        ev.delta_ms = delta;
        return ev;
    endfunction

    function automatic link_event_t packet_event(input logic [2:0] kind,
                                                 input logic [15:0] seq,
                                                 input logic [15:0] ack);
        link_event_t ev;
        ev = noise_event(MODE_PACKET);
        ev.pkt_type        = kind;
        ev.pkt_sequence    = seq;
        ev.pkt_ack         = ack;
        ev.pkt_length      = 11'($urandom_range(MIN_LEN, 11'h7FF));
        ev.pkt_protocol_id = cfg_protocol_id;
        return ev;
    endfunction

    function automatic link_event_t input_event(input logic [15:0] seq);
        link_event_t ev;
        ev = noise_event(MODE_INPUT);
        ev.input_sequence = seq;
        return ev;
    endfunction

    // mostly advance the remote sequence a little; sometimes jump, go back or scatter
    function automatic logic [15:0] next_remote();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) gen_remote = gen_remote + 16'($urandom_range(1, 40));
        else if (pick < 7) gen_remote = gen_remote + 16'($urandom_range(41, 3000));
        else if (pick < 9) return gen_remote - 16'($urandom_range(0, 40));
        else return rand16();
        return gen_remote;
    endfunction

    function automatic logic [15:0] calm_delta();
        int unsigned limit;
        limit = (cfg_heartbeat_ms < cfg_timeout_ms / 2) ? cfg_heartbeat_ms
                                                         : cfg_timeout_ms / 2;
        return 16'($urandom_range(0, limit));
    endfunction

    task automatic queue_event(input link_event_t ev);
        request_queue = {request_queue, ev};
        items_issued++;
    endtask

    task automatic queue_traffic();
        int unsigned pick;
        link_event_t ev;
        logic [2:0]  kind;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            queue_event(input_event(gen_input));
            gen_input = gen_input + 16'd1;
        end else if (pick < 45) begin
            queue_event(packet_event(PT_SNAPSHOT, next_remote(),
                                     gen_input - 16'($urandom_range(1, 24))));
        end else if (pick < 60) begin
            case ($urandom_range(0, 3))
                0:       kind = PT_ACCEPT;
                1:       kind = PT_PONG;
                2:       kind = PT_VOICE;
                default: kind = PT_OTHER;
            endcase
            queue_event(packet_event(kind, next_remote(), rand16()));
        end else if (pick < 80) begin
            queue_event(tick_event(calm_delta()));
        end else if (pick < 90) begin
            case ($urandom_range(0, 5))
                0: begin
                    ev = packet_event(PT_ACCEPT, next_remote(), rand16());
                    ev.pkt_protocol_id = ev.pkt_protocol_id ^ (32'd1 << $urandom_range(0, 31));
                end
                1: begin
                    ev = packet_event(PT_SNAPSHOT, next_remote(), rand16());
                    ev.pkt_length = 11'($urandom_range(0, MIN_LEN - 1));
                end
                2: ev = noise_event(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
                3: ev = noise_event(MODE_CONNECT);
                4: ev = packet_event(PT_SNAPSHOT, next_remote(), rand16());
                default: ev = noise_event(MODE_TICK);
            endcase
            queue_event(ev);
        end else if (pick < 95) begin
            queue_event(tick_event(cfg_heartbeat_ms));
        end else begin
            gen_remote = WRAP_HI + 16'($urandom_range(1, 250));
            queue_event(packet_event(PT_PONG, gen_remote, rand16()));
        end
    endtask

    task automatic queue_sessions(input int unsigned count);
        int unsigned target;
        target = items_issued + count;
        while (items_issued < target) begin
            queue_event(noise_event(MODE_CONNECT));
            repeat ($urandom_range(0, 2)) queue_event(tick_event(calm_delta()));
            queue_event(packet_event(PT_ACCEPT, next_remote(), rand16()));
            repeat ($urandom_range(4, 60)) queue_traffic();
            case ($urandom_range(0, 4))
                0: queue_event(noise_event(MODE_DISCONNECT));
                1: queue_event(packet_event(PT_REJECT, next_remote(), rand16()));
                2: queue_event(packet_event(PT_SERVER_DISC, next_remote(), rand16()));
                3: queue_event(tick_event(16'hFFFF));
                default: ;
            endcase
        end
    endtask

    task automatic wait_drained();
        while (items_accepted != items_issued || expected_records.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge aclk);
    endtask

    // drain, settle, then load all three registers and the idle and stall mix
    task automatic start_phase(input logic [31:0] pid, input logic [15:0] timeout,
                               input logic [15:0] beat, input int unsigned gap_pct,
                               input int unsigned stall_pct);
        wait_drained();
        repeat (10) @(negedge aclk);
        write_register(CFG_PROTOCOL_ID, pid);
        write_register(CFG_TIMEOUT_MS, {16'd0, timeout});
        write_register(CFG_HEARTBEAT_MS, {16'd0, beat});
        cfg_we <= 1'b0;
        cfg_protocol_id  = pid;
        cfg_timeout_ms   = timeout;
        cfg_heartbeat_ms = beat;
        send_idle_pct    = gap_pct;
        recv_stall_pct   = stall_pct;
    endtask

    initial begin
        link_event_t ev;
        logic [15:0] timeout;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        start_phase(32'hFFFF_FFFF, 16'hFFFF, 16'd1000, 30, 30);
        queue_event(tick_event(16'hFFFF));
        queue_event(packet_event(PT_ACCEPT, 16'h0010, 16'h0000));
        queue_event(noise_event(MODE_DISCONNECT));
        queue_event(input_event(16'h1234));
        queue_event(noise_event(MODE_SPARE_FIRST));
        queue_event(noise_event(MODE_SPARE_LAST));
        queue_event(noise_event(MODE_CONNECT));
        queue_event(noise_event(MODE_CONNECT));
        queue_event(tick_event(cfg_heartbeat_ms));
        ev = packet_event(PT_ACCEPT, 16'hFFF0, 16'h0000);
        ev.pkt_protocol_id = '0;
        queue_event(ev);
        ev = packet_event(PT_ACCEPT, 16'hFFF0, 16'h0000);
        ev.pkt_length = MIN_LEN - 11'd1;
        queue_event(ev);
        ev = packet_event(PT_ACCEPT, 16'hFFF0, 16'h0000);
        ev.pkt_length = 11'h7FF;
        queue_event(ev);
        queue_event(packet_event(PT_PONG, 16'hFFEF, 16'h0000));
        queue_event(packet_event(PT_OTHER, 16'hFFF0, 16'h0000));
        queue_event(packet_event(PT_VOICE, 16'h0005, 16'h0000));
        queue_event(packet_event(PT_PONG, 16'h0025, 16'h0000));
        queue_event(packet_event(PT_PONG, 16'h0006, 16'h0000));
        queue_event(packet_event(PT_PONG, 16'h0004, 16'h0000));
        queue_event(input_event(16'hFFFF));
        queue_event(input_event(16'h0000));
        queue_event(packet_event(PT_SNAPSHOT, 16'h0025, 16'h0000));
        queue_event(packet_event(PT_SNAPSHOT, 16'h0025, 16'hFFFF));
        queue_event(tick_event(16'hFFFF));
        queue_event(noise_event(MODE_CONNECT));
        queue_event(packet_event(PT_REJECT, 16'h0026, 16'h0000));
        queue_event(noise_event(MODE_CONNECT));
        queue_event(packet_event(PT_ACCEPT, 16'h0027, 16'h0000));
        queue_event(input_event(16'h0042));
        queue_event(noise_event(MODE_DISCONNECT));
        gen_remote = 16'h0027;
        gen_input  = rand16();

        start_phase(RST_PROTOCOL_ID, RST_TIMEOUT_MS, RST_HEARTBEAT_MS, 25, 25);
        queue_sessions(250);

        start_phase($urandom, 16'd1, 16'd1, 40, 40);
        queue_sessions(80);

        start_phase($urandom, 16'hFFFF, 16'd1, 0, 0);
        queue_sessions(200);

        timeout = 16'($urandom_range(200, 5000));
        start_phase($urandom, timeout, 16'($urandom_range(10, timeout)), 30, 30);
        queue_sessions(250);

        start_phase($urandom, 16'hFFFF, 16'hFFFF, 20, 60);
        gen_input = 16'($urandom_range(0, 1000));
        queue_event(noise_event(MODE_CONNECT));
        queue_event(packet_event(PT_ACCEPT, next_remote(), rand16()));
        repeat (QUEUE_DEPTH + FLOOD_EXTRA) begin
            queue_event(input_event(gen_input));
            gen_input = gen_input + 16'd1;
        end
        queue_event(packet_event(PT_SNAPSHOT, next_remote(), gen_input - 16'd1));
        queue_sessions(150);

        wait_drained();
        repeat (20) @(negedge aclk);
        if (fault_count == 0 && expected_records.size() == 0) begin
            $display("udp_client_link_tracker test passed");
        end else begin
            $display("udp_client_link_tracker test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("udp_client_link_tracker test failed");
        $finish;
    end

endmodule
